@@ design/rlne_pkg.sv @@
package rlne_pkg;

    localparam int MAX_NODES    = 64;
    localparam int MAX_BRANCHES = 256;

    localparam int ND_AW   = $clog2(MAX_NODES);
    localparam int ND_CW   = $clog2(MAX_NODES + 1);
    localparam int BR_AW   = $clog2(MAX_BRANCHES);
    localparam int BR_CW   = $clog2(MAX_BRANCHES + 1);
    localparam int CLR_LEN = (MAX_NODES > MAX_BRANCHES) ? MAX_NODES : MAX_BRANCHES;
    localparam int CLR_AW  = $clog2(CLR_LEN);

    // Width used for intermediate sums before saturation.
    localparam int SAT_W = 68;

    localparam logic [2:0] KIND_SET_NODE    = 3'd0;
    localparam logic [2:0] KIND_SET_BRANCH  = 3'd1;
    localparam logic [2:0] KIND_STEP        = 3'd2;
    localparam logic [2:0] KIND_READ_NODE   = 3'd3;
    localparam logic [2:0] KIND_READ_BRANCH = 3'd4;

    localparam logic [2:0] CFG_STEP_OVER_L = 3'd0;
    localparam logic [2:0] CFG_STEP_OVER_C = 3'd1;
    localparam logic [2:0] CFG_VOLT_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_NODE_COUNT  = 3'd3;
    localparam logic [2:0] CFG_BR_COUNT    = 3'd4;

    localparam logic [31:0] RST_STEP_OVER_L = 32'd16777;
    localparam logic [31:0] RST_STEP_OVER_C = 32'd16777216;
    localparam logic [30:0] RST_VOLT_LIMIT  = 31'd65536000;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CLEAR,
        PH_EXEC,
        PH_B_RD,
        PH_B_V,
        PH_B_DROP,
        PH_B_MUL,
        PH_B_CUR,
        PH_B_SA,
        PH_B_RB,
        PH_B_SB,
        PH_N_RD,
        PH_N_MUL,
        PH_N_DV,
        PH_N_WR
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   load_item;
        logic   br_next;
        logic   nd_next;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic is_step;
        logic nb_zero;
        logic nn_zero;
        logic br_last;
        logic nd_last;
        logic skip;
        logic clr_last;
    } sts_t;

    localparam logic signed [SAT_W-1:0] S32_MAX = 2147483647;
    localparam logic signed [SAT_W-1:0] S32_MIN = ~S32_MAX;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (x < S32_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/rlne_ctrl.sv @@
module rlne_ctrl
    import rlne_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'b0_0000_0000_0000_0001,
        S_IDLE   = 17'b0_0000_0000_0000_0010,
        S_EXEC   = 17'b0_0000_0000_0000_0100,
        S_RDATA  = 17'b0_0000_0000_0000_1000,
        S_B_RD   = 17'b0_0000_0000_0001_0000,
        S_B_V    = 17'b0_0000_0000_0010_0000,
        S_B_DROP = 17'b0_0000_0000_0100_0000,
        S_B_MUL  = 17'b0_0000_0000_1000_0000,
        S_B_CUR  = 17'b0_0000_0001_0000_0000,
        S_B_SA   = 17'b0_0000_0010_0000_0000,
        S_B_RB   = 17'b0_0000_0100_0000_0000,
        S_B_SB   = 17'b0_0000_1000_0000_0000,
        S_N_RD   = 17'b0_0001_0000_0000_0000,
        S_N_MUL  = 17'b0_0010_0000_0000_0000,
        S_N_DV   = 17'b0_0100_0000_0000_0000,
        S_N_WR   = 17'b0_1000_0000_0000_0000,
        S_DONE   = 17'b1_0000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    state_t after_branch;

    // Where the walk goes once the current branch is finished.
    always_comb
    begin
        if (!sts.br_last)
        begin
            after_branch = S_B_RD;
        end
        else if (sts.nn_zero)
        begin
            after_branch = S_DONE;
        end
        else
        begin
            after_branch = S_N_RD;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.phase     = PH_IDLE;
        cmd.load_item = 1'b0;
        cmd.br_next   = 1'b0;
        cmd.nd_next   = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.phase = PH_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.phase = PH_EXEC;
                if (!sts.is_step)
                begin
                    state_next = S_RDATA;
                end
                else if (!sts.nb_zero)
                begin
                    state_next = S_B_RD;
                end
                else if (!sts.nn_zero)
                begin
                    state_next = S_N_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RDATA:
            begin
                state_next = S_DONE;
            end
            S_B_RD:
            begin
                cmd.phase  = PH_B_RD;
                state_next = S_B_V;
            end
            S_B_V:
            begin
                cmd.phase = PH_B_V;
                if (sts.skip)
                begin
                    cmd.br_next = 1'b1;
                    state_next  = after_branch;
                end
                else
                begin
                    state_next = S_B_DROP;
                end
            end
            S_B_DROP:
            begin
                cmd.phase  = PH_B_DROP;
                state_next = S_B_MUL;
            end
            S_B_MUL:
            begin
                cmd.phase  = PH_B_MUL;
                state_next = S_B_CUR;
            end
            S_B_CUR:
            begin
                cmd.phase  = PH_B_CUR;
                state_next = S_B_SA;
            end
            S_B_SA:
            begin
                cmd.phase  = PH_B_SA;
                state_next = S_B_RB;
            end
            S_B_RB:
            begin
                cmd.phase  = PH_B_RB;
                state_next = S_B_SB;
            end
            S_B_SB:
            begin
                cmd.phase   = PH_B_SB;
                cmd.br_next = 1'b1;
                state_next  = after_branch;
            end
            S_N_RD:
            begin
                cmd.phase  = PH_N_RD;
                state_next = S_N_MUL;
            end
            S_N_MUL:
            begin
                cmd.phase  = PH_N_MUL;
                state_next = S_N_DV;
            end
            S_N_DV:
            begin
                cmd.phase  = PH_N_DV;
                state_next = S_N_WR;
            end
            S_N_WR:
            begin
                cmd.phase   = PH_N_WR;
                cmd.nd_next = 1'b1;
                state_next  = sts.nd_last ? S_DONE : S_N_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ design/rlne_datapath.sv @@
module rlne_datapath
    import rlne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [2:0]         kind,
    input  logic [7:0]         slot,
    input  logic signed [31:0] node_level,
    input  logic               node_pinned,
    input  logic [23:0]        ohms,
    input  logic [5:0]         end_left,
    input  logic [5:0]         end_right,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic [31:0]        max_change,
    output logic signed [31:0] read_value,
    output logic signed [31:0] pinned_current,
    output logic               bounds_error,
    output logic               request_error
);

    // Configuration registers.
    logic [31:0] soi_reg, soc_reg;
    logic [30:0] vlim_reg;
    logic [6:0]  ncount_reg;
    logic [8:0]  bcount_reg;

    // Latched item.
    logic [2:0]         kind_reg;
    logic [7:0]         slot_reg;
    logic signed [31:0] level_reg;
    logic               pinned_reg;
    logic [23:0]        ohms_reg;
    logic [5:0]         el_reg, er_reg;

    // Walk counters and step results.
    logic [CLR_AW-1:0] clr_reg;
    logic [BR_CW-1:0]  bidx_reg;
    logic [ND_CW-1:0]  nidx_reg;
    logic [31:0]       best_reg;
    logic              flag_reg;

    // Datapath registers.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [31:0] drop_reg, cur_reg, dv_reg;

    // Output payload.
    logic [31:0]        max_change_reg;
    logic signed [31:0] read_value_reg, pinned_current_reg;
    logic               bounds_error_reg, request_error_reg;

    // Memories: node voltage with pinned bit, node current sum, node net current,
    // branch current, branch resistance and ends.
    logic [32:0] vmem   [MAX_NODES];
    logic [31:0] summem [MAX_NODES];
    logic [31:0] netmem [MAX_NODES];
    logic [31:0] bcmem  [MAX_BRANCHES];
    logic [23:0] ohmmem [MAX_BRANCHES];
    logic [5:0]  lmem   [MAX_BRANCHES];
    logic [5:0]  rmem   [MAX_BRANCHES];

    logic [32:0]        va_q, vb_q;
    logic signed [31:0] sum_q, net_q, bcur_q;
    logic [23:0]        ohm_q;
    logic [5:0]         left_q, right_q;

    logic [ND_AW-1:0] vm_ra, vm_rb, vm_wa, sum_ra, sum_wa, net_ra, net_wa;
    logic [32:0]      vm_wd;
    logic [31:0]      sum_wd, net_wd, bc_wd;
    logic             vm_we, sum_we, net_we, bc_we, meta_we;
    logic [BR_AW-1:0] br_ra, bc_wa, meta_wa;

    logic [ND_CW-1:0] nn;
    logic [BR_CW-1:0] nb;
    logic             slot_nd_ok, slot_br_ok, ends_ok, item_err, br_phase, clr_nd;

    logic signed [SAT_W-1:0] drop_w, cur_w, dv_w, v_w, lim_s, sa_w, sb_w;
    logic signed [31:0]      va_s, vb_s, vnew;
    logic [31:0]             mag;
    logic                    over;

    assign nn = (int'(ncount_reg) > MAX_NODES) ? ND_CW'(MAX_NODES) : ND_CW'(ncount_reg);
    assign nb = (int'(bcount_reg) > MAX_BRANCHES) ? BR_CW'(MAX_BRANCHES) : BR_CW'(bcount_reg);

    assign slot_nd_ok = int'(slot_reg) < int'(nn);
    assign slot_br_ok = int'(slot_reg) < int'(nb);
    assign ends_ok    = (int'(el_reg) < int'(nn)) && (int'(er_reg) < int'(nn));

    always_comb
    begin
        unique case (kind_reg)
            KIND_SET_NODE:    item_err = !slot_nd_ok;
            KIND_SET_BRANCH:  item_err = !(slot_br_ok && ends_ok && (ohms_reg != 24'd0));
            KIND_STEP:        item_err = 1'b0;
            KIND_READ_NODE:   item_err = !slot_nd_ok;
            KIND_READ_BRANCH: item_err = !slot_br_ok;
            default:          item_err = 1'b1;
        endcase
    end

    assign clr_nd = int'(clr_reg) < MAX_NODES;

    assign sts.is_step  = (kind_reg == KIND_STEP);
    assign sts.nb_zero  = (nb == '0);
    assign sts.nn_zero  = (nn == '0);
    assign sts.br_last  = int'(bidx_reg) == int'(nb) - 1;
    assign sts.nd_last  = int'(nidx_reg) == int'(nn) - 1;
    assign sts.skip     = (int'(left_q) >= int'(nn)) || (int'(right_q) >= int'(nn));
    assign sts.clr_last = int'(clr_reg) == CLR_LEN - 1;

    assign br_phase = (cmd.phase == PH_B_RD) || (cmd.phase == PH_B_V) ||
                      (cmd.phase == PH_B_DROP) || (cmd.phase == PH_B_MUL) ||
                      (cmd.phase == PH_B_CUR) || (cmd.phase == PH_B_SA) ||
                      (cmd.phase == PH_B_RB) || (cmd.phase == PH_B_SB);

    // Read addresses.
    always_comb
    begin
        br_ra  = br_phase ? bidx_reg[BR_AW-1:0] : BR_AW'(slot_reg);
        vm_rb  = ND_AW'(right_q);
        net_ra = ND_AW'(slot_reg);
        if (br_phase)
        begin
            vm_ra = ND_AW'(left_q);
        end
        else if ((cmd.phase == PH_N_RD) || (cmd.phase == PH_N_MUL) ||
                 (cmd.phase == PH_N_DV) || (cmd.phase == PH_N_WR))
        begin
            vm_ra = nidx_reg[ND_AW-1:0];
        end
        else
        begin
            vm_ra = ND_AW'(slot_reg);
        end
        case (cmd.phase)
            PH_B_CUR:                    sum_ra = ND_AW'(left_q);
            PH_B_SA, PH_B_RB, PH_B_SB:   sum_ra = ND_AW'(right_q);
            default:                     sum_ra = nidx_reg[ND_AW-1:0];
        endcase
    end

    // Arithmetic.
    assign va_s = va_q[31:0];
    assign vb_s = vb_q[31:0];

    always_comb
    begin
        drop_w = SAT_W'(va_s) - SAT_W'(vb_s) - SAT_W'(prod_reg >>> 16);
        cur_w  = SAT_W'(bcur_q) + SAT_W'(prod_reg >>> 16);
        dv_w   = SAT_W'(prod_reg >>> 32);
        sa_w   = SAT_W'(sum_q) - SAT_W'(cur_reg);
        sb_w   = SAT_W'(sum_q) + SAT_W'(cur_reg);
        v_w    = SAT_W'(va_s) + SAT_W'(dv_reg);
        lim_s  = SAT_W'({1'b0, vlim_reg});
        over   = 1'b0;
        vnew   = v_w[31:0];
        if (v_w > lim_s)
        begin
            vnew = 32'({1'b0, vlim_reg});
            over = 1'b1;
        end
        else if (v_w < -lim_s)
        begin
            vnew = -32'({1'b0, vlim_reg});
            over = 1'b1;
        end
        mag = dv_reg[31] ? (~dv_reg + 32'd1) : dv_reg;
    end

    always_comb
    begin
        case (cmd.phase)
            PH_B_V:
            begin
                mul_a = {bcur_q[31], bcur_q};
                mul_b = {9'd0, ohm_q};
            end
            PH_B_MUL:
            begin
                mul_a = {1'b0, soi_reg};
                mul_b = {drop_reg[31], drop_reg};
            end
            default:
            begin
                mul_a = {sum_q[31], sum_q};
                mul_b = {1'b0, soc_reg};
            end
        endcase
    end

    // Write ports.
    always_comb
    begin
        vm_we   = 1'b0;
        vm_wa   = ND_AW'(slot_reg);
        vm_wd   = {pinned_reg, level_reg};
        sum_we  = 1'b0;
        sum_wa  = nidx_reg[ND_AW-1:0];
        sum_wd  = '0;
        net_we  = 1'b0;
        net_wa  = nidx_reg[ND_AW-1:0];
        net_wd  = '0;
        bc_we   = 1'b0;
        bc_wa   = BR_AW'(slot_reg);
        bc_wd   = '0;
        meta_we = 1'b0;
        meta_wa = BR_AW'(slot_reg);
        case (cmd.phase)
            PH_CLEAR:
            begin
                vm_we  = clr_nd;
                vm_wa  = ND_AW'(clr_reg);
                vm_wd  = '0;
                sum_we = clr_nd;
                sum_wa = ND_AW'(clr_reg);
                net_we = clr_nd;
                net_wa = ND_AW'(clr_reg);
                bc_we  = 1'b1;
                bc_wa  = BR_AW'(clr_reg);
            end
            PH_EXEC:
            begin
                vm_we   = (kind_reg == KIND_SET_NODE) && !item_err;
                bc_we   = (kind_reg == KIND_SET_BRANCH) && !item_err;
                meta_we = (kind_reg == KIND_SET_BRANCH) && !item_err;
            end
            PH_B_CUR:
            begin
                bc_we = 1'b1;
                bc_wa = bidx_reg[BR_AW-1:0];
                bc_wd = sat32(cur_w);
            end
            PH_B_SA:
            begin
                sum_we = 1'b1;
                sum_wa = ND_AW'(left_q);
                sum_wd = sat32(sa_w);
            end
            PH_B_SB:
            begin
                sum_we = 1'b1;
                sum_wa = ND_AW'(right_q);
                sum_wd = sat32(sb_w);
            end
            PH_N_WR:
            begin
                vm_we  = !va_q[32];
                vm_wa  = nidx_reg[ND_AW-1:0];
                vm_wd  = {1'b0, vnew};
                sum_we = 1'b1;
                net_we = 1'b1;
                net_wd = va_q[32] ? sum_q : 32'd0;
            end
            default:
            begin
                vm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vmem[vm_wa] <= vm_wd;
        end
        va_q <= vmem[vm_ra];
        vb_q <= vmem[vm_rb];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            summem[sum_wa] <= sum_wd;
        end
        sum_q <= summem[sum_ra];
    end

    always_ff @(posedge clk)
    begin
        if (net_we)
        begin
            netmem[net_wa] <= net_wd;
        end
        net_q <= netmem[net_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bc_we)
        begin
            bcmem[bc_wa] <= bc_wd;
        end
        bcur_q <= bcmem[br_ra];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            ohmmem[meta_wa] <= ohms_reg;
            lmem[meta_wa]   <= el_reg;
            rmem[meta_wa]   <= er_reg;
        end
        ohm_q   <= ohmmem[br_ra];
        left_q  <= lmem[br_ra];
        right_q <= rmem[br_ra];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg   <= kind;
            slot_reg   <= slot;
            level_reg  <= node_level;
            pinned_reg <= node_pinned;
            ohms_reg   <= ohms;
            el_reg     <= end_left;
            er_reg     <= end_right;
        end
        if ((cmd.phase == PH_B_V) || (cmd.phase == PH_B_MUL) || (cmd.phase == PH_N_MUL))
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.phase == PH_B_DROP)
        begin
            drop_reg <= sat32(drop_w);
        end
        if (cmd.phase == PH_B_CUR)
        begin
            cur_reg <= sat32(cur_w);
        end
        if (cmd.phase == PH_N_DV)
        begin
            dv_reg <= sat32(dv_w);
        end
        if (cmd.out_load)
        begin
            max_change_reg     <= (kind_reg == KIND_STEP) ? best_reg : 32'd0;
            bounds_error_reg   <= flag_reg;
            request_error_reg  <= item_err;
            read_value_reg     <= '0;
            pinned_current_reg <= '0;
            if ((kind_reg == KIND_READ_NODE) && !item_err)
            begin
                read_value_reg     <= va_s;
                pinned_current_reg <= va_q[32] ? net_q : 32'sd0;
            end
            else if ((kind_reg == KIND_READ_BRANCH) && !item_err)
            begin
                read_value_reg <= bcur_q;
            end
        end
    end

    // Control and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soi_reg    <= RST_STEP_OVER_L;
            soc_reg    <= RST_STEP_OVER_C;
            vlim_reg   <= RST_VOLT_LIMIT;
            ncount_reg <= '0;
            bcount_reg <= '0;
            clr_reg    <= '0;
            bidx_reg   <= '0;
            nidx_reg   <= '0;
            best_reg   <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STEP_OVER_L: soi_reg    <= cfg_data;
                    CFG_STEP_OVER_C: soc_reg    <= cfg_data;
                    CFG_VOLT_LIMIT:  vlim_reg   <= cfg_data[30:0];
                    CFG_NODE_COUNT:  ncount_reg <= cfg_data[6:0];
                    CFG_BR_COUNT:    bcount_reg <= cfg_data[8:0];
                    default:         soi_reg    <= soi_reg;
                endcase
            end
            if ((cmd.phase == PH_CLEAR) && !sts.clr_last)
            begin
                clr_reg <= clr_reg + CLR_AW'(1);
            end
            if (cmd.phase == PH_EXEC)
            begin
                bidx_reg <= '0;
                nidx_reg <= '0;
                if (kind_reg == KIND_STEP)
                begin
                    best_reg <= '0;
                end
            end
            if (cmd.br_next)
            begin
                bidx_reg <= bidx_reg + BR_CW'(1);
            end
            if (cmd.nd_next)
            begin
                nidx_reg <= nidx_reg + ND_CW'(1);
            end
            // Pinned nodes do not move and take no part in the largest change.
            if ((cmd.phase == PH_N_WR) && !va_q[32])
            begin
                if (mag > best_reg)
                begin
                    best_reg <= mag;
                end
                if (over)
                begin
                    flag_reg <= 1'b1;
                end
            end
        end
    end

    assign max_change     = max_change_reg;
    assign read_value     = read_value_reg;
    assign pinned_current = pinned_current_reg;
    assign bounds_error   = bounds_error_reg;
    assign request_error  = request_error_reg;

endmodule

@@ design/rl_network_euler_step_top.sv @@
// Channel   Direction  Handshake            Payload
// in        into       in_valid / in_stall  kind, slot, node_level, node_pinned, ohms,
//                                           end_left, end_right
// out       out of     out_valid/out_stall  max_change, read_value, pinned_current,
//                                           bounds_error, request_error
// cfg       into       cfg_we               cfg_index, cfg_data
//
// Set and read transactions pass the execute, read-data and done states. A time step
// walks each branch in use (read, voltage, drop, multiply, current, sum updates; one
// with a stale end stops after voltage), then each node in use (read, multiply,
// change, write); the shared multiplier and one-port sum memory of the branch walk
// set its length. On reset node and branch current memories clear with in_stall high.
// A finished result waits in the output register; a transaction that finishes
// while that register is still stalled waits there before the next is taken.
module rl_network_euler_step_top
    import rlne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [7:0]         slot,
    input  logic signed [31:0] node_level,
    input  logic               node_pinned,
    input  logic [23:0]        ohms,
    input  logic [5:0]         end_left,
    input  logic [5:0]         end_right,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        max_change,
    output logic signed [31:0] read_value,
    output logic signed [31:0] pinned_current,
    output logic               bounds_error,
    output logic               request_error,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cmd_t cmd;
    sts_t sts;

    rlne_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rlne_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .slot           (slot),
        .node_level     (node_level),
        .node_pinned    (node_pinned),
        .ohms           (ohms),
        .end_left       (end_left),
        .end_right      (end_right),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .max_change     (max_change),
        .read_value     (read_value),
        .pinned_current (pinned_current),
        .bounds_error   (bounds_error),
        .request_error  (request_error)
    );

    // An accepted transaction keeps the input closed while it is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transaction is in progress");

    // The bounds flag is sticky from one result to the next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bounds_error) |=> (!out_valid || bounds_error))
        else $error("bounds flag cleared without reset");

    // A rejected transaction reports no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && request_error) |->
        (max_change == 32'd0 && read_value == 32'sd0 && pinned_current == 32'sd0))
        else $error("rejected transaction carries data");

endmodule
